@@ src/ripts_pkg.sv @@
// Shared types and constants for the in-path target selector.
// No dependencies; every other file of the block imports this package.
package ripts_pkg;

  localparam int TRACK_SLOTS_DEF = 64;
  localparam int CFG_W           = 14;
  localparam logic [7:0] HOLD_MAX = 8'hFF;

  localparam logic [13:0] INNER_RESET = 14'd96;
  localparam logic [13:0] OUTER_RESET = 14'd128;
  localparam logic [13:0] SPEED_RESET = 14'd64;

  typedef enum logic [1:0] {
    REG_INNER = 2'd0,
    REG_OUTER = 2'd1,
    REG_SPEED = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_TENTATIVE = 2'd1,
    ST_VERIFIED  = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    UPD_KEEP = 2'd0,
    UPD_SET  = 2'd1,
    UPD_CLR  = 2'd2
  } upd_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_SUB, F_ABS, F_CMP, F_PUSH
  } fst_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RD_V, B_CHK_V, B_CHK_S, B_SCAN, B_DONE
  } bst_t;

  // classified track request passed from front to back
  typedef struct packed {
    logic [5:0]         idx;
    logic [1:0]         status;
    logic               stat;
    logic signed [14:0] pos_x;
    logic               spd_ok;
    upd_t               upd;
    logic               last;
  } ripts_item_t;

  // per-slot store word
  typedef struct packed {
    logic [1:0]         status;
    logic               stat;
    logic signed [14:0] pos_x;
    logic               spd_ok;
  } ripts_entry_t;

  typedef struct packed {
    logic       cipv_valid;
    logic [5:0] cipv_index;
    logic [7:0] cipv_hold_count;
    logic       cips_valid;
    logic [5:0] cips_index;
  } ripts_result_t;

endpackage

@@ src/radar_in_path_target_selector_core.sv @@
// Radar closest in-path target selector: top level joining front, queue and back.
// Depends on ripts_pkg, ripts_front, ripts_queue and ripts_back.
//
// Tracks of a frame are pushed one request at a time, in slot order. After taking
// a request the front works out the lateral path offset of the track in steps
// (multiply, subtract, magnitude, compare, hand-over) and takes no new track until
// the hand-over is done, which waits while the queue is full; a two-entry queue
// lets the front keep taking tracks while the back is busy. The back stores each
// track while idle. On the track marked last it checks the current choices and
// walks every slot through the store's single read port, then loads one result
// (CIPV, its hold count and CIPS) into the output register. No clearing pass is
// needed after reset.
module radar_in_path_target_selector_core #(
  parameter int TRACK_SLOTS = ripts_pkg::TRACK_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_data,
  input  logic                in_push,
  output logic                in_full,
  input  logic [5:0]          in_track_index,
  input  logic [1:0]          in_track_status,
  input  logic                in_is_stationary,
  input  logic signed [14:0]  in_pos_x,
  input  logic signed [14:0]  in_pos_y,
  input  logic signed [13:0]  in_vel_x,
  input  logic signed [13:0]  in_ego_speed,
  input  logic signed [17:0]  in_path_radius,
  input  logic                in_last_track,
  output logic                out_empty,
  input  logic                pop,
  output logic                out_cipv_valid,
  output logic [5:0]          out_cipv_index,
  output logic [7:0]          out_cipv_hold_count,
  output logic                out_cips_valid,
  output logic [5:0]          out_cips_index
);
  import ripts_pkg::*;

  logic f_push, f_full, b_pop, b_empty;
  ripts_item_t f_item, b_item;
  ripts_result_t res;

  ripts_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_full, .in_track_index, .in_track_status, .in_is_stationary,
    .in_pos_x, .in_pos_y, .in_vel_x, .in_ego_speed, .in_path_radius,
    .in_last_track,
    .q_push(f_push), .q_full(f_full), .q_item(f_item)
  );

  ripts_queue u_queue (
    .clk, .rst_n,
    .push(f_push), .full(f_full), .wr_item(f_item),
    .pop(b_pop), .empty(b_empty), .rd_item(b_item)
  );

  ripts_back #(.TRACK_SLOTS(TRACK_SLOTS)) u_back (
    .clk, .rst_n,
    .q_empty(b_empty), .q_pop(b_pop), .q_item(b_item),
    .out_empty, .out_pop(pop), .res
  );

  assign out_cipv_valid      = res.cipv_valid;
  assign out_cipv_index      = res.cipv_index;
  assign out_cipv_hold_count = res.cipv_hold_count;
  assign out_cips_valid      = res.cips_valid;
  assign out_cips_index      = res.cips_index;

endmodule

@@ src/ripts_front.sv @@
// Front part: configuration registers, track intake and in-path classification.
// Depends on ripts_pkg.
module ripts_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [13:0]           cfg_data,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [5:0]            in_track_index,
  input  logic [1:0]            in_track_status,
  input  logic                  in_is_stationary,
  input  logic signed [14:0]    in_pos_x,
  input  logic signed [14:0]    in_pos_y,
  input  logic signed [13:0]    in_vel_x,
  input  logic signed [13:0]    in_ego_speed,
  input  logic signed [17:0]    in_path_radius,
  input  logic                  in_last_track,
  output logic                  q_push,
  input  logic                  q_full,
  output ripts_pkg::ripts_item_t q_item
);
  import ripts_pkg::*;

  fst_t state_r, state_nxt;

  logic [13:0] inner_r, outer_r;
  logic signed [13:0] speed_r;

  ripts_item_t item_r;
  logic signed [14:0] x_r, y_r;
  logic [17:0] absr_r;
  logic signed [17:0] r_r;
  logic rzero_r;

  logic signed [29:0] xx_r;
  logic signed [32:0] ry_r;
  logic [31:0] ia_r, oa_r;
  logic signed [38:0] num_r;
  logic [37:0] nabs_r;

  logic signed [32:0] r_ext, y_ext;
  logic signed [14:0] spd_sum, spd_min;
  logic [17:0] absr_in;
  logic signed [38:0] xx_ext, ry_sh;
  logic [37:0] ith, oth;
  upd_t upd_c;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= INNER_RESET;
      outer_r <= OUTER_RESET;
      speed_r <= SPEED_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_INNER: inner_r <= cfg_data;
        REG_OUTER: outer_r <= cfg_data;
        REG_SPEED: speed_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_push) state_nxt = F_MUL;
      F_MUL:  state_nxt = F_SUB;
      F_SUB:  state_nxt = F_ABS;
      F_ABS:  state_nxt = F_CMP;
      F_CMP:  state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_full = (state_r != F_IDLE);
    q_push  = (state_r == F_PUSH);
    accept  = (state_r == F_IDLE) && in_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    spd_sum = 15'(in_vel_x) + 15'(in_ego_speed);
    spd_min = speed_r;
    absr_in = in_path_radius[17] ? 18'(-in_path_radius) : 18'(in_path_radius);
    r_ext   = r_r;
    y_ext   = y_r;
    xx_ext  = xx_r;
    ry_sh   = 39'(ry_r) <<< 5;
    ith     = 38'(ia_r) << 5;
    oth     = 38'(oa_r) << 5;
    if (item_r.status != ST_VERIFIED) upd_c = UPD_KEEP;
    else if (rzero_r)                 upd_c = UPD_CLR;
    else if (nabs_r < ith)            upd_c = UPD_SET;
    else if (nabs_r > oth)            upd_c = UPD_CLR;
    else                              upd_c = UPD_KEEP;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.idx    <= in_track_index;
      item_r.status <= in_track_status;
      item_r.stat   <= in_is_stationary;
      item_r.pos_x  <= in_pos_x;
      item_r.spd_ok <= (spd_sum > spd_min);
      item_r.upd    <= UPD_KEEP;
      item_r.last   <= in_last_track;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      r_r     <= in_path_radius;
      absr_r  <= absr_in;
      rzero_r <= (in_path_radius == '0);
    end
    if (state_r == F_MUL) begin
      xx_r <= x_r * x_r;
      ry_r <= r_ext * y_ext;
      ia_r <= 32'(inner_r) * 32'(absr_r);
      oa_r <= 32'(outer_r) * 32'(absr_r);
    end
    if (state_r == F_SUB) num_r <= xx_ext - ry_sh;
    if (state_r == F_ABS) nabs_r <= num_r[38] ? 38'(-num_r) : 38'(num_r);
    if (state_r == F_CMP) item_r.upd <= upd_c;
  end

  assign q_item = item_r;

endmodule

@@ src/ripts_queue.sv @@
// Two-entry queue carrying classified track requests from front to back.
// Depends on ripts_pkg.
module ripts_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  ripts_pkg::ripts_item_t wr_item,
  input  logic                  pop,
  output logic                  empty,
  output ripts_pkg::ripts_item_t rd_item
);
  import ripts_pkg::*;

  ripts_item_t slots_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ src/ripts_back.sv @@
// Back part: per-slot store, in-path flags, end-of-frame scan and result register.
// Depends on ripts_pkg.
module ripts_back #(
  parameter int TRACK_SLOTS = ripts_pkg::TRACK_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  ripts_pkg::ripts_item_t q_item,
  output logic                   out_empty,
  input  logic                   out_pop,
  output ripts_pkg::ripts_result_t res
);
  import ripts_pkg::*;

  localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TRACK_SLOTS + 1);

  bst_t state_r, state_nxt;

  ripts_entry_t store [TRACK_SLOTS];
  ripts_entry_t rd_r;
  logic         flag_rd_r;
  logic [TRACK_SLOTS-1:0] flags_r;

  logic [SLOT_W-1:0] rd_addr, wr_addr;
  logic [CNT_W-1:0]  cnt_r;
  logic slot_ok, do_wr, scan_end, out_load;

  logic              vval_r, sval_r;
  logic [SLOT_W-1:0] vch_r, sch_r;
  logic [7:0]        hold_r;

  logic              kept_v_r, kept_s_r, found_v_r, found_s_r;
  logic              bv_r, bs_r;
  logic [SLOT_W-1:0] bvi_r, bsi_r;
  logic signed [14:0] bvd_r, bsd_r;

  logic cand_v, cand_s, take_v, take_s, same_v;
  logic [7:0] hold_new;

  ripts_result_t res_r;
  logic          res_valid_r;

  assign slot_ok  = ({2'b00, q_item.idx} < 8'(TRACK_SLOTS));
  assign wr_addr  = SLOT_W'(q_item.idx);
  assign scan_end = (cnt_r == CNT_W'(TRACK_SLOTS - 1));
  assign out_load = !res_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty && q_item.last) state_nxt = B_RD_V;
      B_RD_V:  state_nxt = B_CHK_V;
      B_CHK_V: state_nxt = B_CHK_S;
      B_CHK_S: state_nxt = B_SCAN;
      B_SCAN:  if (scan_end) state_nxt = B_DONE;
      B_DONE:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == B_IDLE) && !q_empty;
    do_wr = q_pop && slot_ok;
    case (state_r)
      B_RD_V:  rd_addr = vch_r;
      B_CHK_V: rd_addr = sch_r;
      B_SCAN:  rd_addr = SLOT_W'(cnt_r + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    cand_v = flag_rd_r && !rd_r.stat && rd_r.spd_ok;
    cand_s = flag_rd_r && rd_r.stat;
    take_v = cand_v && (!bv_r || rd_r.pos_x < bvd_r);
    take_s = cand_s && (!bs_r || rd_r.pos_x < bsd_r);
    same_v = bv_r && kept_v_r && (bvi_r == vch_r);
    hold_new = (!same_v) ? 8'd0 : (hold_r == HOLD_MAX) ? HOLD_MAX : hold_r + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_addr] <= '{status: q_item.status, stat: q_item.stat,
                          pos_x: q_item.pos_x, spd_ok: q_item.spd_ok};
    end
    rd_r <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      flags_r     <= '0;
      flag_rd_r   <= 1'b0;
      vval_r      <= 1'b0;
      sval_r      <= 1'b0;
      vch_r       <= '0;
      sch_r       <= '0;
      hold_r      <= 8'd0;
      res_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      flag_rd_r <= flags_r[rd_addr];
      if (do_wr) begin
        case (q_item.upd)
          UPD_SET: flags_r[wr_addr] <= 1'b1;
          UPD_CLR: flags_r[wr_addr] <= 1'b0;
          default: ;
        endcase
      end
      if (state_r == B_DONE && out_load) begin
        res_valid_r <= 1'b1;
        vval_r <= found_v_r && bv_r;
        vch_r  <= bvi_r;
        hold_r <= found_v_r ? hold_new : 8'd0;
        sval_r <= found_s_r && bs_r;
        sch_r  <= bsi_r;
      end else if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // drop stale choices, then scan every slot
  always_ff @(posedge clk) begin
    case (state_r)
      B_CHK_V: begin
        kept_v_r <= vval_r && (rd_r.status != ST_NONE) && flag_rd_r;
        bv_r  <= vval_r && (rd_r.status != ST_NONE) && flag_rd_r;
        bvi_r <= vch_r;
        bvd_r <= rd_r.pos_x;
      end
      B_CHK_S: begin
        kept_s_r <= sval_r && (rd_r.status != ST_NONE) && rd_r.stat && flag_rd_r;
        bs_r  <= sval_r && (rd_r.status != ST_NONE) && rd_r.stat && flag_rd_r;
        bsi_r <= sch_r;
        bsd_r <= rd_r.pos_x;
        found_v_r <= 1'b0;
        found_s_r <= 1'b0;
        cnt_r <= '0;
      end
      B_SCAN: begin
        cnt_r <= cnt_r + 1'b1;
        if (cand_v) found_v_r <= 1'b1;
        if (cand_s) found_s_r <= 1'b1;
        if (take_v) begin
          bv_r  <= 1'b1;
          bvi_r <= SLOT_W'(cnt_r);
          bvd_r <= rd_r.pos_x;
        end
        if (take_s) begin
          bs_r  <= 1'b1;
          bsi_r <= SLOT_W'(cnt_r);
          bsd_r <= rd_r.pos_x;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == B_DONE && out_load) begin
      res_r.cipv_valid      <= found_v_r && bv_r;
      res_r.cipv_index      <= (found_v_r && bv_r) ? 6'(bvi_r) : 6'd0;
      res_r.cipv_hold_count <= (found_v_r && bv_r) ? hold_new : 8'd0;
      res_r.cips_valid      <= found_s_r && bs_r;
      res_r.cips_index      <= (found_s_r && bs_r) ? 6'(bsi_r) : 6'd0;
    end
  end

  assign out_empty = !res_valid_r;
  assign res       = res_r;

endmodule
